// ===== rtl/greek_dead_key_translator_defines.svh =====
// Assertion macros for the Greek dead-key translator RTL.
`ifndef GREEK_DEAD_KEY_TRANSLATOR_DEFINES_SVH
`define GREEK_DEAD_KEY_TRANSLATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define GDK_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdk same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define GDK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdk next-cycle check failed");

`endif

// ===== rtl/gdk_pkg.sv =====
// Types, key codes and letter tables for the Greek dead-key translator.
package gdk_pkg;

  // Layout and pending diacritic state
  typedef struct packed {
    logic       greek;
    logic [1:0] marks;
  } gdk_state_t;

  // One translated result
  typedef struct packed {
    logic        pressed;
    logic [15:0] value;
  } gdk_result_t;

  // Special key bytes
  localparam logic [7:0] KEY_NONE      = 8'h00;
  localparam logic [7:0] KEY_EXTENDED  = 8'hE0;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_DOLLAR    = 8'h24;
  localparam logic [7:0] KEY_DIALYTIKA = 8'h04;
  localparam logic [7:0] KEY_ENTER     = 8'h0D;
  localparam logic [7:0] KEY_LO_A      = 8'h61;
  localparam logic [7:0] KEY_LO_Z      = 8'h7A;
  localparam logic [7:0] KEY_UP_A      = 8'h41;
  localparam logic [7:0] KEY_UP_Z      = 8'h5A;
  localparam logic [7:0] KEY_LO_Q      = 8'h71;
  localparam logic [7:0] KEY_UP_Q      = 8'h51;
  localparam logic [7:0] CHR_SEMICOLON = 8'h3B;
  localparam logic [7:0] CHR_COLON     = 8'h3A;
  localparam logic [15:0] VAL_ENTER    = 16'd10;

  // Mark bits
  localparam logic [1:0] MARK_TONOS     = 2'b01;
  localparam logic [1:0] MARK_DIALYTIKA = 2'b10;
  localparam logic [1:0] MARK_BOTH      = 2'b11;

  // Matrix row bits
  localparam int ROW_ALT_BIT   = 4;
  localparam int ROW_SPACE_BIT = 5;

  // Encode a code point below 0x400 as a UTF-8 pair, lead byte low
  function automatic logic [15:0] utf8_pair(input logic [9:0] cp);
    utf8_pair = {2'b10, cp[5:0], 4'b1100, cp[9:6]};
  endfunction

  // Greek code point for a Latin letter index, lower case
  function automatic logic [9:0] lower_cp(input logic [4:0] idx);
    case (idx)
      5'd0:  lower_cp = 10'h3B1;
      5'd1:  lower_cp = 10'h3B2;
      5'd2:  lower_cp = 10'h3C8;
      5'd3:  lower_cp = 10'h3B4;
      5'd4:  lower_cp = 10'h3B5;
      5'd5:  lower_cp = 10'h3C6;
      5'd6:  lower_cp = 10'h3B3;
      5'd7:  lower_cp = 10'h3B7;
      5'd8:  lower_cp = 10'h3B9;
      5'd9:  lower_cp = 10'h3BE;
      5'd10: lower_cp = 10'h3BA;
      5'd11: lower_cp = 10'h3BB;
      5'd12: lower_cp = 10'h3BC;
      5'd13: lower_cp = 10'h3BD;
      5'd14: lower_cp = 10'h3BF;
      5'd15: lower_cp = 10'h3C0;
      5'd17: lower_cp = 10'h3C1;
      5'd18: lower_cp = 10'h3C3;
      5'd19: lower_cp = 10'h3C4;
      5'd20: lower_cp = 10'h3B8;
      5'd21: lower_cp = 10'h3C9;
      5'd22: lower_cp = 10'h3C2;
      5'd23: lower_cp = 10'h3C7;
      5'd24: lower_cp = 10'h3C5;
      5'd25: lower_cp = 10'h3B6;
      default: lower_cp = 10'h000;
    endcase
  endfunction

  // Greek code point for a Latin letter index, upper case
  function automatic logic [9:0] upper_cp(input logic [4:0] idx);
    case (idx)
      5'd0:  upper_cp = 10'h391;
      5'd1:  upper_cp = 10'h392;
      5'd2:  upper_cp = 10'h3A8;
      5'd3:  upper_cp = 10'h394;
      5'd4:  upper_cp = 10'h395;
      5'd5:  upper_cp = 10'h3A6;
      5'd6:  upper_cp = 10'h393;
      5'd7:  upper_cp = 10'h397;
      5'd8:  upper_cp = 10'h399;
      5'd9:  upper_cp = 10'h39E;
      5'd10: upper_cp = 10'h39A;
      5'd11: upper_cp = 10'h39B;
      5'd12: upper_cp = 10'h39C;
      5'd13: upper_cp = 10'h39D;
      5'd14: upper_cp = 10'h39F;
      5'd15: upper_cp = 10'h3A0;
      5'd17: upper_cp = 10'h3A1;
      5'd18: upper_cp = 10'h3A3;
      5'd19: upper_cp = 10'h3A4;
      5'd20: upper_cp = 10'h398;
      5'd21: upper_cp = 10'h3A9;
      5'd22: upper_cp = 10'h3A3;
      5'd23: upper_cp = 10'h3A7;
      5'd24: upper_cp = 10'h3A5;
      5'd25: upper_cp = 10'h396;
      default: upper_cp = 10'h000;
    endcase
  endfunction

  // Plain Greek mapping of a key byte
  function automatic logic [15:0] plain_greek(input logic [7:0] key);
    logic [7:0] lo_off;
    logic [7:0] up_off;
    lo_off = key - KEY_LO_A;
    up_off = key - KEY_UP_A;
    if (key == KEY_LO_Q) begin
      plain_greek = {8'h00, CHR_SEMICOLON};
    end else if (key == KEY_UP_Q) begin
      plain_greek = {8'h00, CHR_COLON};
    end else if (key >= KEY_LO_A && key <= KEY_LO_Z) begin
      plain_greek = utf8_pair(lower_cp(lo_off[4:0]));
    end else if (key >= KEY_UP_A && key <= KEY_UP_Z) begin
      plain_greek = utf8_pair(upper_cp(up_off[4:0]));
    end else begin
      plain_greek = {8'h00, key};
    end
  endfunction

  // Accented code point for a key and mark set, zero when none exists
  function automatic logic [9:0] accented_cp(input logic [7:0] key, input logic [1:0] marks);
    accented_cp = 10'h000;
    if (marks == MARK_TONOS) begin
      case (key)
        8'h61:   accented_cp = 10'h3AC; // a
        8'h65:   accented_cp = 10'h3AD; // e
        8'h68:   accented_cp = 10'h3AE; // h
        8'h69:   accented_cp = 10'h3AF; // i
        8'h6F:   accented_cp = 10'h3CC; // o
        8'h79:   accented_cp = 10'h3CD; // y
        8'h76:   accented_cp = 10'h3CE; // v
        8'h41:   accented_cp = 10'h386; // A
        8'h45:   accented_cp = 10'h388; // E
        8'h48:   accented_cp = 10'h389; // H
        8'h49:   accented_cp = 10'h38A; // I
        8'h4F:   accented_cp = 10'h38C; // O
        8'h59:   accented_cp = 10'h38E; // Y
        8'h56:   accented_cp = 10'h38F; // V
        default: accented_cp = 10'h000;
      endcase
    end else if (marks == MARK_DIALYTIKA || marks == MARK_BOTH) begin
      case (key)
        8'h69:   accented_cp = (marks == MARK_BOTH) ? 10'h390 : 10'h3CA; // i
        8'h79:   accented_cp = (marks == MARK_BOTH) ? 10'h3B0 : 10'h3CB; // y
        8'h49:   accented_cp = 10'h3AA; // I
        8'h59:   accented_cp = 10'h3AB; // Y
        default: accented_cp = 10'h000;
      endcase
    end
  endfunction

endpackage

// ===== rtl/gdk_xlate.sv =====
// Combinational key translation and next-state logic for one poll.
module gdk_xlate (
  input  logic                read_ok,
  input  logic [7:0]          key_code,
  input  logic                matrix_ok,
  input  logic [7:0]          matrix_row0,
  input  gdk_pkg::gdk_state_t state,
  output gdk_pkg::gdk_state_t state_next,
  output gdk_pkg::gdk_result_t result
);
  import gdk_pkg::*;

  logic       ignore;
  logic       toggle;
  logic       dead_tonos;
  logic       dead_dial;
  logic [9:0] acc_cp;

  // Classify the request
  assign ignore     = !read_ok || key_code == KEY_NONE || key_code == KEY_EXTENDED;
  assign toggle     = key_code == KEY_SPACE && matrix_ok &&
                      matrix_row0[ROW_ALT_BIT] && matrix_row0[ROW_SPACE_BIT];
  assign dead_tonos = state.greek && key_code == KEY_DOLLAR;
  assign dead_dial  = state.greek && key_code == KEY_DIALYTIKA;
  assign acc_cp     = accented_cp(key_code, state.marks);

  // Pick the result and the new layout and marks
  always_comb begin
    state_next     = state;
    result.pressed = 1'b0;
    result.value   = 16'h0000;
    if (ignore) begin
      state_next = state;
    end else if (toggle) begin
      state_next.greek = !state.greek;
      state_next.marks = 2'b00;
    end else if (dead_tonos) begin
      state_next.marks = state.marks | MARK_TONOS;
    end else if (dead_dial) begin
      state_next.marks = state.marks | MARK_DIALYTIKA;
    end else begin
      result.pressed   = 1'b1;
      state_next.marks = 2'b00;
      if (key_code == KEY_ENTER) begin
        result.value = VAL_ENTER;
      end else if (state.greek) begin
        if (state.marks != 2'b00 && acc_cp != 10'h000) begin
          result.value = utf8_pair(acc_cp);
        end else begin
          result.value = plain_greek(key_code);
        end
      end else if (key_code == KEY_DIALYTIKA) begin
        result.value = {8'h00, KEY_DOLLAR};
      end else begin
        result.value = {8'h00, key_code};
      end
    end
  end

endmodule

// ===== rtl/greek_dead_key_translator.sv =====
// Top level of the Greek dead-key translator: input register, state, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_stall  | read_ok, key_code, matrix_ok, matrix_row0
//   out     | output    | out_valid / out_stall| pressed, key_value, greek_active,
//           |           |                      | marks_pending
//
// One request per cycle sustained while out_stall is low; a taken request is held in the input
// register and then moves into the result register. The translation is combinational logic between them.
// Layout and marks advance when a request moves into the result register.
// out_stall holds the result register and, once the input register is full, raises in_stall.
// Reset (rst, synchronous) empties both stages and selects English with no marks pending.
module greek_dead_key_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        read_ok,
  input  logic [7:0]  key_code,
  input  logic        matrix_ok,
  input  logic [7:0]  matrix_row0,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pressed,
  output logic [15:0] key_value,
  output logic        greek_active,
  output logic [1:0]  marks_pending
);
  import gdk_pkg::*;

  `include "greek_dead_key_translator_defines.svh"

  logic        s1_valid;
  logic        s1_read_ok;
  logic [7:0]  s1_key;
  logic        s1_matrix_ok;
  logic [7:0]  s1_row0;
  gdk_state_t  state;
  gdk_state_t  state_next;
  gdk_result_t result;
  logic        s1_load;
  logic        s2_load;

  // Advance the pipeline when the next stage has room
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  gdk_xlate u_xlate (
    .read_ok     (s1_read_ok),
    .key_code    (s1_key),
    .matrix_ok   (s1_matrix_ok),
    .matrix_row0 (s1_row0),
    .state       (state),
    .state_next  (state_next),
    .result      (result)
  );

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
    if (s1_load) begin
      s1_read_ok   <= read_ok;
      s1_key       <= key_code;
      s1_matrix_ok <= matrix_ok;
      s1_row0      <= matrix_row0;
    end
  end

  // Update layout and marks as each request is translated
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s2_load) begin
      state <= state_next;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s2_load) begin
      pressed       <= result.pressed;
      key_value     <= result.value;
      greek_active  <= state_next.greek;
      marks_pending <= state_next.marks;
    end
  end

  `GDK_ASSERT_SAME(a_release_zero, out_valid && !pressed, key_value == 16'h0000)
  `GDK_ASSERT_SAME(a_out_matches_state, out_valid, greek_active == state.greek && marks_pending == state.marks)
  `GDK_ASSERT_NEXT(a_state_hold, !s2_load, $stable(state))
  `GDK_ASSERT_SAME(a_stall_needs_full, in_stall, s1_valid && out_valid && out_stall)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the Greek dead-key translator: directed, random and backpressure tests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gdk_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 48;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 50;

  // Greek code points per Latin letter, entry 0 ('a' / 'A') in the low bits
  localparam logic [26*11-1:0] LOWER_POINTS = {
    11'h3B6, 11'h3C5, 11'h3C7, 11'h3C2, 11'h3C9, 11'h3B8, 11'h3C4, 11'h3C3, 11'h3C1,
    11'h000, 11'h3C0, 11'h3BF, 11'h3BD, 11'h3BC, 11'h3BB, 11'h3BA, 11'h3BE, 11'h3B9,
    11'h3B7, 11'h3B3, 11'h3C6, 11'h3B5, 11'h3B4, 11'h3C8, 11'h3B2, 11'h3B1};
  localparam logic [26*11-1:0] UPPER_POINTS = {
    11'h396, 11'h3A5, 11'h3A7, 11'h3A3, 11'h3A9, 11'h398, 11'h3A4, 11'h3A3, 11'h3A1,
    11'h000, 11'h3A0, 11'h39F, 11'h39D, 11'h39C, 11'h39B, 11'h39A, 11'h39E, 11'h399,
    11'h397, 11'h393, 11'h3A6, 11'h395, 11'h394, 11'h3A8, 11'h392, 11'h391};
  // Letters that carry an accented form
  localparam logic [14*8-1:0] ACCENT_KEYS = "aehioyvAEHIOYV";

  typedef struct packed {
    logic       read_ok;
    logic [7:0] key;
    logic       matrix_ok;
    logic [7:0] row0;
  } poll_t;

  typedef struct packed {
    logic        pressed;
    logic [15:0] value;
    logic        greek;
    logic [1:0]  marks;
  } keyout_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        read_ok     = 1'b0;
  logic [7:0]  key_code    = 8'h00;
  logic        matrix_ok   = 1'b0;
  logic [7:0]  matrix_row0 = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        pressed;
  logic [15:0] key_value;
  logic        greek_active;
  logic [1:0]  marks_pending;

  // Predictor state and expected results
  logic        greek_mode;
  logic [1:0]  mark_set;
  keyout_t     expected_keys[$];

  int   mismatches = 0;
  int   sent_keys  = 0;
  int   idle_cycles = 0;
  int   hold_reqs  = 0;
  int   hold_seen  = 0;
  int   stall_left = 0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;

  greek_dead_key_translator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .read_ok      (read_ok),
    .key_code     (key_code),
    .matrix_ok    (matrix_ok),
    .matrix_row0  (matrix_row0),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pressed      (pressed),
    .key_value    (key_value),
    .greek_active (greek_active),
    .marks_pending(marks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Two-byte UTF-8, lead byte in the low half
  function automatic logic [15:0] utf8_of(input logic [10:0] cp);
    utf8_of = {2'b10, cp[5:0], 3'b110, cp[10:6]};
  endfunction

  function automatic logic [15:0] greek_plain(input logic [7:0] k);
    logic [7:0] idx;
    idx = 8'h00;
    if (k == KEY_LO_Q) begin
      greek_plain = {8'h00, CHR_SEMICOLON};
    end else if (k == KEY_UP_Q) begin
      greek_plain = {8'h00, CHR_COLON};
    end else if (k >= KEY_LO_A && k <= KEY_LO_Z) begin
      idx = k - KEY_LO_A;
      greek_plain = utf8_of(LOWER_POINTS[idx*11 +: 11]);
    end else if (k >= KEY_UP_A && k <= KEY_UP_Z) begin
      idx = k - KEY_UP_A;
      greek_plain = utf8_of(UPPER_POINTS[idx*11 +: 11]);
    end else begin
      greek_plain = {8'h00, k};
    end
  endfunction

  // Accented code point for a letter under a mark set, zero when there is none
  function automatic logic [10:0] accent_point(input logic [7:0] k, input logic [1:0] m);
    accent_point = 11'h000;
    if (m == MARK_TONOS) begin
      case (k)
        "a": accent_point = 11'h3AC;
        "e": accent_point = 11'h3AD;
        "h": accent_point = 11'h3AE;
        "i": accent_point = 11'h3AF;
        "o": accent_point = 11'h3CC;
        "y": accent_point = 11'h3CD;
        "v": accent_point = 11'h3CE;
        "A": accent_point = 11'h386;
        "E": accent_point = 11'h388;
        "H": accent_point = 11'h389;
        "I": accent_point = 11'h38A;
        "O": accent_point = 11'h38C;
        "Y": accent_point = 11'h38E;
        "V": accent_point = 11'h38F;
        default: accent_point = 11'h000;
      endcase
    end else if (m == MARK_DIALYTIKA || m == MARK_BOTH) begin
      case (k)
        "i": accent_point = (m == MARK_BOTH) ? 11'h390 : 11'h3CA;
        "y": accent_point = (m == MARK_BOTH) ? 11'h3B0 : 11'h3CB;
        "I": accent_point = 11'h3AA;
        "Y": accent_point = 11'h3AB;
        default: accent_point = 11'h000;
      endcase
    end
  endfunction

  function automatic bit is_ignored(input poll_t p);
    is_ignored = !p.read_ok || p.key == KEY_NONE || p.key == KEY_EXTENDED;
  endfunction

  // Translate one poll and advance layout and marks
  function automatic keyout_t translate_poll(input poll_t p);
    keyout_t     r;
    logic        taken;
    logic [1:0]  m;
    logic [10:0] cp;
    r = '0;
    taken = 1'b0;
    if (!is_ignored(p)) begin
      if (p.key == KEY_SPACE && p.matrix_ok && p.row0[ROW_ALT_BIT] && p.row0[ROW_SPACE_BIT]) begin
        greek_mode = !greek_mode;
        mark_set = 2'b00;
        taken = 1'b1;
      end else if (greek_mode && p.key == KEY_DOLLAR) begin
        mark_set = mark_set | MARK_TONOS;
        taken = 1'b1;
      end else if (greek_mode && p.key == KEY_DIALYTIKA) begin
        mark_set = mark_set | MARK_DIALYTIKA;
        taken = 1'b1;
      end
      if (!taken) begin
        r.pressed = 1'b1;
        m = mark_set;
        mark_set = 2'b00;
        if (p.key == KEY_ENTER) begin
          r.value = VAL_ENTER;
        end else if (greek_mode) begin
          cp = (m != 2'b00) ? accent_point(p.key, m) : 11'h000;
          r.value = (cp != 11'h000) ? utf8_of(cp) : greek_plain(p.key);
        end else begin
          r.value = (p.key == KEY_DIALYTIKA) ? {8'h00, KEY_DOLLAR} : {8'h00, p.key};
        end
      end
    end
    r.greek = greek_mode;
    r.marks = mark_set;
    return r;
  endfunction

  // Offer one request, wait for it to be taken, record its expected result
  task automatic send_poll(input poll_t p);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    read_ok     <= p.read_ok;
    key_code    <= p.key;
    matrix_ok   <= p.matrix_ok;
    matrix_row0 <= p.row0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_keys.insert(expected_keys.size(), translate_poll(p));
    if (!is_ignored(p)) sent_keys++;
  endtask

  function automatic poll_t key_poll(input logic [7:0] k);
    poll_t p;
    p.read_ok   = 1'b1;
    p.key       = k;
    p.matrix_ok = 1'($urandom_range(0, 1));
    p.row0      = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic poll_t space_poll(input logic ok, input logic [7:0] row);
    poll_t p;
    p.read_ok   = 1'b1;
    p.key       = KEY_SPACE;
    p.matrix_ok = ok;
    p.row0      = row;
    return p;
  endfunction

  function automatic poll_t noise_poll();
    poll_t p;
    p.read_ok   = 1'($urandom_range(0, 1));
    p.key       = 8'($urandom_range(0, 255));
    p.matrix_ok = 1'($urandom_range(0, 1));
    p.row0      = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic poll_t toggle_poll();
    poll_t p;
    p = space_poll(1'b1, 8'($urandom_range(0, 255)));
    p.row0[ROW_ALT_BIT]   = 1'b1;
    p.row0[ROW_SPACE_BIT] = 1'b1;
    return p;
  endfunction

  function automatic logic [7:0] random_letter();
    int idx;
    if ($urandom_range(0, 1)) begin
      idx = $urandom_range(0, 13);
      random_letter = ACCENT_KEYS[idx*8 +: 8];
    end else if ($urandom_range(0, 1)) begin
      random_letter = KEY_LO_A + 8'($urandom_range(0, 25));
    end else begin
      random_letter = KEY_UP_A + 8'($urandom_range(0, 25));
    end
  endfunction

  // Dead keys followed by a letter
  task automatic send_word();
    int n_dead;
    n_dead = $urandom_range(0, 2);
    repeat (n_dead) send_poll(key_poll($urandom_range(0, 1) ? KEY_DOLLAR : KEY_DIALYTIKA));
    send_poll(key_poll(random_letter()));
  endtask

  task automatic send_random_item();
    poll_t p;
    p = noise_poll();
    case ($urandom_range(0, 19))
      0, 1: send_poll(p);
      2: begin
        // Drop the read or use a byte the block skips
        if ($urandom_range(0, 1)) begin
          p.read_ok = 1'b0;
        end else begin
          p.read_ok = 1'b1;
          p.key = $urandom_range(0, 1) ? KEY_NONE : KEY_EXTENDED;
        end
        send_poll(p);
      end
      3: send_poll(toggle_poll());
      4: begin
        // Space without the full chord
        p = space_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        if (p.matrix_ok) p.row0[$urandom_range(ROW_ALT_BIT, ROW_SPACE_BIT)] = 1'b0;
        send_poll(p);
      end
      5: send_poll(key_poll(KEY_ENTER));
      6: begin
        // Dead key broken off by an arbitrary byte
        send_poll(key_poll($urandom_range(0, 1) ? KEY_DOLLAR : KEY_DIALYTIKA));
        send_poll(key_poll(8'($urandom_range(1, 255))));
      end
      7: send_poll(key_poll(8'($urandom_range(1, 255))));
      default: send_word();
    endcase
  endtask

  // Report one mismatch; keep the log short on a badly broken block
  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic test_directed();
    poll_t p;
    // Skipped reads
    p = noise_poll();
    p.read_ok = 1'b0;
    p.key = 8'hFF;
    p.matrix_ok = 1'b1;
    p.row0 = 8'hFF;
    send_poll(p);
    send_poll(key_poll(KEY_NONE));
    send_poll(key_poll(KEY_EXTENDED));
    // English mode
    send_poll(key_poll(KEY_ENTER));
    send_poll(key_poll(KEY_DIALYTIKA));
    send_poll(key_poll(KEY_DOLLAR));
    send_poll(key_poll("a"));
    send_poll(space_poll(1'b0, 8'hFF));
    send_poll(space_poll(1'b1, 8'h10));
    // Switch to Greek
    send_poll(space_poll(1'b1, 8'h30));
    send_poll(key_poll("q"));
    send_poll(key_poll("z"));
    // Tonos, dialytika, both, and a letter with no accented form
    send_poll(key_poll(KEY_DOLLAR));
    send_poll(key_poll("a"));
    send_poll(key_poll(KEY_DIALYTIKA));
    send_poll(key_poll("i"));
    send_poll(key_poll(KEY_DOLLAR));
    send_poll(key_poll(KEY_DIALYTIKA));
    send_poll(key_poll("y"));
    send_poll(key_poll(KEY_DIALYTIKA));
    send_poll(key_poll("A"));
    // Enter and a layout switch both clear pending marks
    send_poll(key_poll(KEY_DOLLAR));
    send_poll(key_poll(KEY_ENTER));
    send_poll(key_poll(KEY_DIALYTIKA));
    send_poll(space_poll(1'b1, 8'hFF));
  endtask

  task automatic test_random_mix(input int count);
    int goal;
    goal = sent_keys + count;
    while (sent_keys < goal) send_random_item();
  endtask

  // Hold the result side while requests keep coming so the input stalls
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_reqs++;
    repeat (30) send_random_item();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_steady_stream(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(count);
  endtask

  // Result side stall: random short bursts and requested long holds
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      stall_left <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    keyout_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_keys.size() == 0) begin
        report_mismatch("unexpected result", key_value, 16'h0000);
      end else begin
        want = expected_keys.pop_front();
        if (pressed !== want.pressed)
          report_mismatch("pressed", {15'h0000, pressed}, {15'h0000, want.pressed});
        if (key_value !== want.value) report_mismatch("key_value", key_value, want.value);
        if (greek_active !== want.greek)
          report_mismatch("greek_active", {15'h0000, greek_active}, {15'h0000, want.greek});
        if (marks_pending !== want.marks)
          report_mismatch("marks_pending", {14'h0000, marks_pending}, {14'h0000, want.marks});
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_tests
    greek_mode = 1'b0;
    mark_set   = 2'b00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(530);
    test_backpressure();
    test_steady_stream(100);
    in_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== greek_dead_key_translator.f =====
+incdir+rtl
rtl/gdk_pkg.sv
rtl/gdk_xlate.sv
rtl/greek_dead_key_translator.sv
sim/testbench.sv
